// ===== src/masked_byte_pattern_search_top_defines.svh =====
// Assertion macros shared by the masked byte pattern search RTL
`ifndef MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MBPS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("masked byte pattern search check failed");

// Next-cycle implication, checked outside reset
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("masked byte pattern search check failed");

`endif

// ===== src/mbps_pkg.sv =====
// Types and constants of the masked byte pattern search
package mbps_pkg;

   localparam int MAX_PATTERN_BYTES = 24;
   localparam int OFFSET_BITS       = 24;
   localparam int COUNT_BITS        = OFFSET_BITS + 1;
   localparam int LEN_BITS          = 5;
   localparam int CSR_DATA_BITS     = 64;
   localparam int CSR_INDEX_BITS    = 3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_0 = 3'd0,
      CSR_PATTERN_1 = 3'd1,
      CSR_PATTERN_2 = 3'd2,
      CSR_IGNORE_0  = 3'd3,
      CSR_IGNORE_1  = 3'd4,
      CSR_IGNORE_2  = 3'd5,
      CSR_LENGTH    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [OFFSET_BITS-1:0] match_offset;
   } rsp_type;

   typedef logic [MAX_PATTERN_BYTES-1:0][7:0] byte_row_type;

endpackage

// ===== src/masked_byte_pattern_search_top.sv =====
// Top level of the masked byte pattern search: window, compare and result buffer
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_data (data_byte, last_byte)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data (found, match_offset)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One byte is taken per cycle unless req_stall is set; any result is registered.
// The window shift, masked lane compare and offset subtract form one register stage.
// A two-entry result buffer keeps req flowing until rsp_stall fills its skid entry.
// reset is synchronous; it clears the search state and sets the length to one.
// csr writes are always ready and take effect on the next byte.
`include "masked_byte_pattern_search_top_defines.svh"

module masked_byte_pattern_search_top
   import mbps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_0_ff, pattern_1_ff, pattern_2_ff;
   logic [CSR_DATA_BITS-1:0] ignore_0_ff, ignore_1_ff, ignore_2_ff;
   logic [LEN_BITS-1:0]      length_ff;

   // Search state
   byte_row_type           window_ff, window_in, window_new;
   logic [COUNT_BITS-1:0]  bytes_seen_ff, bytes_seen_in, bytes_new;
   logic                   reported_ff, reported_in;

   // Result buffer
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_ff, skid_in;

   byte_row_type          pat_bytes, ign_bytes;
   logic [LEN_BITS-1:0]   eff_len;
   logic [LEN_BITS-1:0]   lane_sel [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] lane_active, lane_ok;
   logic [COUNT_BITS-1:0] len_wide, start;
   logic                  count_ok, hit, accept, push, pop;
   rsp_type               result;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   assign pat_bytes = {pattern_2_ff, pattern_1_ff, pattern_0_ff};
   assign ign_bytes = {ignore_2_ff, ignore_1_ff, ignore_0_ff};

   // Clamp the configured length into 1..MAX_PATTERN_BYTES
   always_comb begin
      priority if (length_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (length_ff > LEN_BITS'(MAX_PATTERN_BYTES)) begin
         eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
      end else begin
         eff_len = length_ff;
      end
   end

   // Shift the new byte into the window and count it, saturating
   always_comb begin
      window_new[0] = req_data.data_byte;
      for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
         window_new[j] = window_ff[j-1];
      end
      bytes_new = (bytes_seen_ff == COUNT_MAX) ? bytes_seen_ff : bytes_seen_ff + 1'b1;
   end

   // Compare each window lane with its aligned pattern byte under the mask
   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         lane_active[j] = LEN_BITS'(j) < eff_len;
         lane_sel[j]    = lane_active[j] ? (eff_len - LEN_BITS'(1) - LEN_BITS'(j)) : '0;
         lane_ok[j]     = !lane_active[j] ||
                          (((window_new[j] ^ pat_bytes[lane_sel[j]]) &
                            ~ign_bytes[lane_sel[j]]) == 8'h00);
      end
   end

   // Check the start offset exists and fits
   assign len_wide = COUNT_BITS'(eff_len);
   assign start    = bytes_new - len_wide;
   assign count_ok = (bytes_new >= len_wide) && ((start >> OFFSET_BITS) == '0);
   assign hit      = !reported_ff && count_ok && (&lane_ok);

   // Form the result transaction
   always_comb begin
      result.found        = hit;
      result.match_offset = hit ? start[OFFSET_BITS-1:0] : '0;
      push = accept && (hit || (req_data.last_byte && !reported_ff));
   end

   // Advance the search state; re-arm after the final byte
   always_comb begin
      window_in     = window_ff;
      bytes_seen_in = bytes_seen_ff;
      reported_in   = reported_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            window_in     = '0;
            bytes_seen_in = '0;
            reported_in   = 1'b0;
         end else begin
            window_in     = window_new;
            bytes_seen_in = bytes_new;
            reported_in   = reported_ff || hit;
         end
      end
   end

   // Steer results between the output register and the skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Hold configuration; write on a csr transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_0_ff <= '0;
         pattern_1_ff <= '0;
         pattern_2_ff <= '0;
         ignore_0_ff  <= '0;
         ignore_1_ff  <= '0;
         ignore_2_ff  <= '0;
         length_ff    <= LEN_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PATTERN_0: pattern_0_ff <= csr_wdata;
            CSR_PATTERN_1: pattern_1_ff <= csr_wdata;
            CSR_PATTERN_2: pattern_2_ff <= csr_wdata;
            CSR_IGNORE_0:  ignore_0_ff  <= csr_wdata;
            CSR_IGNORE_1:  ignore_1_ff  <= csr_wdata;
            CSR_IGNORE_2:  ignore_2_ff  <= csr_wdata;
            CSR_LENGTH:    length_ff    <= csr_wdata[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control and search state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         bytes_seen_ff <= '0;
         reported_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         window_ff     <= window_in;
         bytes_seen_ff <= bytes_seen_in;
         reported_ff   <= reported_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   `MBPS_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `MBPS_ASSERT_NEXT(a_rearm_after_last, clock, reset, accept && req_data.last_byte, bytes_seen_ff == '0 && !reported_ff)
   `MBPS_ASSERT_IMPLY(a_notfound_on_last, clock, reset, push && !result.found, req_data.last_byte)
   `MBPS_ASSERT_IMPLY(a_reported_has_bytes, clock, reset, reported_ff, bytes_seen_ff != '0)

endmodule

// ===== dv/masked_byte_pattern_search_top_test.sv =====
// Self-checking testbench of the masked byte pattern search top level
module masked_byte_pattern_search_top_test;
   import mbps_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_BYTES   = 115;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Register copies seen by the predictor
   logic [2:0][63:0]    pattern_words;
   logic [2:0][63:0]    ignore_words;
   logic [LEN_BITS-1:0] length_code;

   // Search state of the predictor
   byte_row_type          window_bytes;
   logic [COUNT_BITS-1:0] seen_count;
   bit                    match_sent;

   rsp_type     awaited_results[$];
   req_type     bytes_to_send[$];
   rsp_type     next_result;
   rsp_type     oldest;
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned error_count = 0;
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;

   // Pattern of the current phase, used to build matching buffers
   byte_row_type plan_pattern;
   byte_row_type plan_ignore;
   int unsigned  plan_span = 1;

   masked_byte_pattern_search_top uut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Clamp the length code to the usable pattern size
   function automatic int unsigned effective_span(input logic [LEN_BITS-1:0] code);
      if (code == 0)
         return 1;
      if (code > MAX_PATTERN_BYTES)
         return MAX_PATTERN_BYTES;
      return 32'(code);
   endfunction

   // Advance the search by one byte; return 1 when the byte yields a result
   function automatic bit search_byte(input req_type item, output rsp_type outcome);
      byte_row_type          pat;
      byte_row_type          ign;
      int unsigned           span;
      logic [COUNT_BITS-1:0] start;
      bit                    hit;
      bit                    made;
      pat = pattern_words;
      ign = ignore_words;
      span = effective_span(length_code);
      hit = 1'b0;
      made = 1'b0;
      start = '0;
      outcome = '0;
      window_bytes = {window_bytes[MAX_PATTERN_BYTES-2:0], item.data_byte};
      if (seen_count != COUNT_MAX)
         seen_count = seen_count + 1'b1;
      if (!match_sent && seen_count >= span) begin
         start = COUNT_BITS'(seen_count - span);
         // offsets beyond the result field are never reported
         if ((start >> OFFSET_BITS) == 0) begin
            hit = 1'b1;
            for (int k = 0; k < span; k++) begin
               if (((window_bytes[span-1-k] ^ pat[k]) & ~ign[k]) != 8'h00)
                  hit = 1'b0;
            end
         end
      end
      if (hit) begin
         outcome.found = 1'b1;
         outcome.match_offset = start[OFFSET_BITS-1:0];
         match_sent = 1'b1;
         made = 1'b1;
      end else if (item.last_byte && !match_sent) begin
         made = 1'b1;
      end
      // re-arm for the next buffer
      if (item.last_byte) begin
         window_bytes = '0;
         seen_count = '0;
         match_sent = 1'b0;
      end
      return made;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Track register writes
   always @(posedge clock) begin
      if (reset) begin
         pattern_words = '0;
         ignore_words = '0;
         length_code = 5'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_0: pattern_words[0] = csr_wdata;
            CSR_PATTERN_1: pattern_words[1] = csr_wdata;
            CSR_PATTERN_2: pattern_words[2] = csr_wdata;
            CSR_IGNORE_0:  ignore_words[0] = csr_wdata;
            CSR_IGNORE_1:  ignore_words[1] = csr_wdata;
            CSR_IGNORE_2:  ignore_words[2] = csr_wdata;
            CSR_LENGTH:    length_code = csr_wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Drive byte transactions and predict their results
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         window_bytes = '0;
         seen_count = '0;
         match_sent = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (search_byte(req_data, next_result))
               awaited_results.push_back(next_result);
            bytes_taken++;
         end
         // hold a stalled transaction, otherwise load the next one or idle
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
               gap_left = $urandom_range(0, 14);
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= bytes_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result with nothing awaited", 32'(rsp_data.match_offset), 0);
         end else begin
            oldest = awaited_results.pop_front();
            if (rsp_data.found !== oldest.found)
               report_mismatch("found", 32'(rsp_data.found), 32'(oldest.found));
            if (rsp_data.match_offset !== oldest.match_offset)
               report_mismatch("match_offset", 32'(rsp_data.match_offset),
                               32'(oldest.match_offset));
         end
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every register, optionally poke the unused index too
   task automatic apply_settings(input logic [2:0][63:0] pw, input logic [2:0][63:0] iw,
                                 input logic [63:0] len_word, input bit poke_spare);
      write_register(CSR_PATTERN_0, pw[0]);
      write_register(CSR_PATTERN_1, pw[1]);
      write_register(CSR_PATTERN_2, pw[2]);
      write_register(CSR_IGNORE_0, iw[0]);
      write_register(CSR_IGNORE_1, iw[1]);
      write_register(CSR_IGNORE_2, iw[2]);
      write_register(CSR_LENGTH, len_word);
      if (poke_spare)
         write_register(CSR_SPARE_INDEX, {$urandom, $urandom});
      csr_valid <= 1'b0;
      plan_pattern = pw;
      plan_ignore = iw;
      plan_span = effective_span(len_word[LEN_BITS-1:0]);
   endtask

   task automatic queue_byte(input logic [7:0] value, input bit last);
      req_type item;
      item.data_byte = value;
      item.last_byte = last;
      bytes_to_send.push_back(item);
      bytes_queued++;
   endtask

   // Pattern byte with random content in its don't-care bits
   function automatic logic [7:0] planted_byte(input int unsigned k);
      return plan_pattern[k] ^ (8'($urandom_range(0, 255)) & plan_ignore[k]);
   endfunction

   // Build one buffer: mostly planted patterns, some broken, noisy or short
   task automatic queue_buffer(input bit exact);
      logic [7:0]  body[$];
      logic [7:0]  b;
      int unsigned shape, lead, tail, copies, flip_at, n, k;
      shape = exact ? 0 : $urandom_range(0, 9);
      if (exact || shape == 9)
         lead = 0;
      else if ($urandom_range(0, 49) == 0)
         lead = $urandom_range(260, 300);
      else
         lead = $urandom_range(0, 10);
      tail = (exact || shape == 9) ? 0 : $urandom_range(0, 6);
      copies = (shape == 6) ? 2 : 1;
      flip_at = $urandom_range(0, plan_span - 1);
      for (n = 0; n < lead; n++)
         body.push_back(8'($urandom_range(0, 255)));
      if (shape <= 7) begin
         for (n = 0; n < copies; n++) begin
            for (k = 0; k < plan_span; k++) begin
               b = planted_byte(k);
               if (shape == 7 && k == flip_at)
                  b = b ^ (8'd1 << $urandom_range(0, 7));
               body.push_back(b);
            end
         end
      end else if (shape == 9) begin
         // buffer ends one byte before the pattern could complete
         for (k = 0; k + 1 < plan_span; k++)
            body.push_back(planted_byte(k));
      end
      for (n = 0; n < tail; n++)
         body.push_back(8'($urandom_range(0, 255)));
      if (body.size() == 0)
         body.push_back(8'($urandom_range(0, 255)));
      foreach (body[i])
         queue_byte(body[i], i == body.size() - 1);
   endtask

   // Wait until every byte is taken and every result is in, then let the pipe settle
   task automatic drain();
      while (bytes_taken != bytes_queued || awaited_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic int unsigned pick_pressure();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 10;
         2: return 25;
         default: return 50;
      endcase
   endfunction

   initial begin
      int unsigned      p, w, pick, phase_start;
      logic [2:0][63:0] pw, iw;
      logic [63:0]      len_word;
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one-byte pattern of zero, match on the first byte, then not-found
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hFF, 1'b1);
      drain();

      // length code zero behaves as one
      pw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pw[0][7:0] = 8'hFF;
      apply_settings(pw, '0, 64'd0, 1'b0);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'hFF, 1'b1);
      drain();

      // oversized length code with high garbage bits; short buffer gives not-found
      apply_settings(pw, '1, '1, 1'b0);
      queue_byte(8'h5A, 1'b1);
      drain();

      // two-byte pattern with a partial mask; unused index write must not land
      pw[0][15:0] = 16'hABCD;
      iw = '0;
      iw[0][15:8] = 8'h0F;
      apply_settings(pw, iw, 64'd2, 1'b1);
      queue_byte(8'hCD, 1'b0);
      queue_byte(8'hAB, 1'b0);
      queue_byte(8'hCD, 1'b0);
      queue_byte(8'hA0, 1'b1);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hCD, 1'b0);
      queue_byte(8'hA7, 1'b1);
      drain();

      // random phases, each under fresh settings
      for (p = 0; p < RANDOM_PHASES; p++) begin
         for (w = 0; w < 3; w++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               pw[w] = 64'd0;
            else if (pick == 1 || p == 3)
               pw[w] = {64{1'b1}};
            else
               pw[w] = {$urandom, $urandom};
            pick = $urandom_range(0, 9);
            if (p == 3 || pick < 4)
               iw[w] = 64'd0;
            else if (pick == 4 || p == 4)
               iw[w] = {64{1'b1}};
            else if (pick == 5)
               iw[w] = {$urandom, $urandom};
            else
               iw[w] = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         end
         case (p)
            0: len_word = 64'd24;
            1: len_word = 64'd1;
            2: len_word = {{59{1'b1}}, 5'd0};
            default: begin
               if ($urandom_range(0, 3) == 0)
                  len_word = {$urandom, $urandom};
               else
                  len_word = 64'($urandom_range(1, MAX_PATTERN_BYTES));
            end
         endcase
         // no idling in the closing phases
         if (p >= RANDOM_PHASES - 2) begin
            req_gap_pct = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct = pick_pressure();
            rsp_stall_pct = pick_pressure();
         end
         apply_settings(pw, iw, len_word, $urandom_range(0, 3) == 0);
         phase_start = bytes_queued;
         queue_buffer(1'b1);
         while (bytes_queued - phase_start < PHASE_BYTES)
            queue_buffer(1'b0);
         drain();
      end

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #(CLOCK_PERIOD * 1_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/mbps_pkg.sv
src/masked_byte_pattern_search_top.sv
dv/masked_byte_pattern_search_top_test.sv
